[hw/rtl/cache_record_validator_core_assert.svh]
// Assertion macros for the cache record validator.
// Included by files that check their own logic; no other dependencies.
`ifndef CACHE_RECORD_VALIDATOR_CORE_ASSERT_SVH
`define CACHE_RECORD_VALIDATOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CRV_ASSERT_NOW(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("crv assertion failed");
// next-cycle implication
`define CRV_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("crv assertion failed");
`else
`define CRV_ASSERT_NOW(name, clk, rstn, ante, cons)
`define CRV_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/crv_pkg.sv]
// Shared types, codes and constants of the cache record validator.
// No dependencies; used by the front end, queue, back end, top level and testbench.
package crv_pkg;

	localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
	localparam int          CHECK_BYTES = 8;
	localparam int          MIN_TOTAL   = 4 + 4 + 8 + 4 + 4 + CHECK_BYTES;
	localparam int          QUEUE_DEPTH = 4;
	localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		PH_MAGIC,
		PH_VERSION,
		PH_KEY,
		PH_COUNT,
		PH_NAMELEN,
		PH_NAME,
		PH_IHASH,
		PH_SIZE,
		PH_CODE,
		PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK,
		ST_SHORT,
		ST_CHECKSUM,
		ST_MAGIC,
		ST_VERSION,
		ST_INCLUDES,
		ST_TRUNCATED,
		ST_BC_SIZE,
		ST_LEN_MISMATCH
	} status_t;

	typedef enum logic [1:0] {
		REG_MAGIC,
		REG_VERSION,
		REG_INC_LIMIT,
		REG_BC_LIMIT
	} crv_reg_t;

	typedef struct packed {
		logic [31:0] magic;
		logic [31:0] version;
		logic [15:0] include_limit;
		logic [24:0] bytecode_limit;
	} crv_cfg_t;

	// one queue entry: a body byte leaving the delay line and/or the end of a record
	typedef struct packed {
		logic        body_vld;
		logic [7:0]  body_byte;
		logic        last;
		logic [63:0] stored;
		logic [3:0]  tail_fill;
	} crv_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} crv_qstat_t;

	// FNV-1a 64 step; the prime 2^40 + 0x1b3 is a shift-add
	function automatic logic [63:0] fnv_step(input logic [63:0] hash, input logic [7:0] b);
		logic [63:0] x;
		x = hash ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

[hw/rtl/crv_ifs.sv]
// Valid/ready stream interfaces of the cache record validator:
// record bytes in, verdicts out. No dependencies.
interface crv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crv_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [63:0] record_key;
	logic [15:0] include_total;
	logic [31:0] bytecode_bytes;

	modport source (output valid, output status, output record_key, output include_total,
		output bytecode_bytes, input ready);
	modport sink (input valid, input status, input record_key, input include_total,
		input bytecode_bytes, output ready);
endinterface

[hw/rtl/crv_front.sv]
// Front end: accepts record bytes, holds back the trailing 8 bytes and
// queues body bytes and end-of-record markers. Depends on crv_pkg, crv_ifs.
module crv_front import crv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	crv_in_if.sink      rec_in,
	input  crv_qstat_t  qstat,
	output logic        push,
	output crv_entry_t  push_data
);

	logic [7:0] tail_q [CHECK_BYTES];
	logic [7:0] tail_d [CHECK_BYTES];
	logic [3:0] fill_q;
	logic [3:0] fill_d;
	logic       tail_full;
	logic       accept;

	assign rec_in.ready = !qstat.full;
	assign accept       = rec_in.valid && rec_in.ready;
	assign tail_full    = (fill_q == 4'(CHECK_BYTES));

	always_comb begin
		for (int i = 0; i < CHECK_BYTES; i++) begin
			tail_d[i] = tail_q[i];
		end
		if (tail_full) begin
			for (int i = 0; i < CHECK_BYTES - 1; i++) begin
				tail_d[i] = tail_q[i + 1];
			end
			tail_d[CHECK_BYTES - 1] = rec_in.data_byte;
		end else begin
			tail_d[fill_q[2:0]] = rec_in.data_byte;
		end
		fill_d = tail_full ? fill_q : fill_q + 4'd1;
	end

	always_comb begin
		push_data.body_vld  = tail_full;
		push_data.body_byte = tail_q[0];
		push_data.last      = rec_in.last_byte;
		push_data.tail_fill = fill_d;
		for (int i = 0; i < CHECK_BYTES; i++) begin
			push_data.stored[8*i +: 8] = tail_d[i];
		end
	end

	// queue only what the back end has to act on
	assign push = accept && (tail_full || rec_in.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < CHECK_BYTES; i++) begin
				tail_q[i] <= '0;
			end
		end else if (accept) begin
			if (rec_in.last_byte) begin
				fill_q <= '0;
				for (int i = 0; i < CHECK_BYTES; i++) begin
					tail_q[i] <= '0;
				end
			end else begin
				fill_q <= fill_d;
				for (int i = 0; i < CHECK_BYTES; i++) begin
					tail_q[i] <= tail_d[i];
				end
			end
		end
	end

endmodule

[hw/rtl/crv_queue.sv]
// Short FIFO between the front and back ends of the validator.
// Depends on crv_pkg for the entry type and depth.
module crv_queue import crv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  crv_entry_t  push_data,
	input  logic        pop,
	output crv_entry_t  head,
	output crv_qstat_t  stat
);

	crv_entry_t          slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign head       = slots_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/crv_back.sv]
// Back end: FNV-1a hash and field parser over body bytes, verdict stage
// and output register. Depends on crv_pkg, crv_ifs.
module crv_back import crv_pkg::*; #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  crv_cfg_t    cfg,
	input  crv_entry_t  head,
	input  crv_qstat_t  qstat,
	output logic        pop,
	crv_out_if.source   verdict_out
);

	// record state
	logic [63:0]            hash_q, hash_d;
	logic [LENGTH_BITS-1:0] body_cnt_q, body_cnt_d;
	phase_t                 phase_q, phase_d;
	logic [63:0]            shift_q, shift_d;
	logic [2:0]             fidx_q, fidx_d;
	logic [15:0]            inc_left_q, inc_left_d;
	logic [15:0]            name_left_q, name_left_d;
	logic [63:0]            key_q, key_d;
	logic [15:0]            count_q, count_d;
	logic [31:0]            size_q, size_d;
	logic [LENGTH_BITS-1:0] code_seen_q, code_seen_d;
	status_t                err_q, err_d;

	// verdict stage
	logic                   vld_s2;
	logic [63:0]            hash_s2;
	logic [63:0]            stored_s2;
	logic [LENGTH_BITS-1:0] body_cnt_s2;
	logic [3:0]             fill_s2;
	logic                   in_code_s2;
	logic [LENGTH_BITS-1:0] code_seen_s2;
	logic [63:0]            key_s2;
	logic [15:0]            count_s2;
	logic [31:0]            size_s2;
	status_t                err_s2;
	status_t                status_s2;

	// output register
	logic                   out_vld_q;
	status_t                out_status_q;
	logic [63:0]            out_key_q;
	logic [15:0]            out_count_q;
	logic [31:0]            out_size_q;

	logic                   adv_s2;
	logic [63:0]            fval;
	logic [2:0]             last_idx;
	logic [LENGTH_BITS:0]   total;

	assign adv_s2 = vld_s2 && (!out_vld_q || verdict_out.ready);
	assign pop    = !qstat.empty && (!head.last || !vld_s2 || adv_s2);

	always_comb begin
		case (phase_q)
			PH_KEY, PH_IHASH: last_idx = 3'd7;
			PH_NAMELEN:       last_idx = 3'd1;
			default:          last_idx = 3'd3;
		endcase
		fval = shift_q | ({56'd0, head.body_byte} << {fidx_q, 3'b000});
	end

	always_comb begin
		hash_d      = hash_q;
		body_cnt_d  = body_cnt_q;
		phase_d     = phase_q;
		shift_d     = shift_q;
		fidx_d      = fidx_q;
		inc_left_d  = inc_left_q;
		name_left_d = name_left_q;
		key_d       = key_q;
		count_d     = count_q;
		size_d      = size_q;
		code_seen_d = code_seen_q;
		err_d       = err_q;
		if (head.body_vld) begin
			hash_d = fnv_step(hash_q, head.body_byte);
			if (body_cnt_q != '1) begin
				body_cnt_d = body_cnt_q + 1'b1;
			end
			case (phase_q)
				PH_DONE: begin
					phase_d = PH_DONE;
				end
				PH_CODE: begin
					if (code_seen_q != '1) begin
						code_seen_d = code_seen_q + 1'b1;
					end
				end
				PH_NAME: begin
					name_left_d = name_left_q - 16'd1;
					if (name_left_d == '0) begin
						phase_d = PH_IHASH;
					end
				end
				default: begin
					if (fidx_q != last_idx) begin
						shift_d = fval;
						fidx_d  = fidx_q + 3'd1;
					end else begin
						shift_d = '0;
						fidx_d  = '0;
						case (phase_q)
							PH_MAGIC: begin
								if (fval[31:0] != cfg.magic && err_d == ST_OK) begin
									err_d = ST_MAGIC;
								end
								phase_d = PH_VERSION;
							end
							PH_VERSION: begin
								if (fval[31:0] != cfg.version && err_d == ST_OK) begin
									err_d = ST_VERSION;
								end
								phase_d = PH_KEY;
							end
							PH_KEY: begin
								key_d   = fval;
								phase_d = PH_COUNT;
							end
							PH_COUNT: begin
								count_d = (|fval[31:16]) ? 16'hFFFF : fval[15:0];
								if (fval[31:0] > {16'd0, cfg.include_limit} && err_d == ST_OK) begin
									err_d = ST_INCLUDES;
								end
								if (err_d != ST_OK) begin
									phase_d = PH_DONE;
								end else begin
									inc_left_d = fval[15:0];
									phase_d    = (fval[15:0] == '0) ? PH_SIZE : PH_NAMELEN;
								end
							end
							PH_NAMELEN: begin
								name_left_d = fval[15:0];
								phase_d     = (fval[15:0] == '0) ? PH_IHASH : PH_NAME;
							end
							PH_IHASH: begin
								inc_left_d = inc_left_q - 16'd1;
								phase_d    = (inc_left_d == '0) ? PH_SIZE : PH_NAMELEN;
							end
							PH_SIZE: begin
								size_d = fval[31:0];
								if (fval[31:0] == '0 || fval[31:0] > {7'd0, cfg.bytecode_limit}
										|| fval[1:0] != 2'b00) begin
									if (err_d == ST_OK) begin
										err_d = ST_BC_SIZE;
									end
									phase_d = PH_DONE;
								end else begin
									phase_d = PH_CODE;
								end
							end
							default: begin
								phase_d = phase_q;
							end
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= FNV_BASIS;
			body_cnt_q  <= '0;
			phase_q     <= PH_MAGIC;
			shift_q     <= '0;
			fidx_q      <= '0;
			inc_left_q  <= '0;
			name_left_q <= '0;
			key_q       <= '0;
			count_q     <= '0;
			size_q      <= '0;
			code_seen_q <= '0;
			err_q       <= ST_OK;
		end else if (pop) begin
			if (head.last) begin
				// record done: back to the reset state
				hash_q      <= FNV_BASIS;
				body_cnt_q  <= '0;
				phase_q     <= PH_MAGIC;
				shift_q     <= '0;
				fidx_q      <= '0;
				inc_left_q  <= '0;
				name_left_q <= '0;
				key_q       <= '0;
				count_q     <= '0;
				size_q      <= '0;
				code_seen_q <= '0;
				err_q       <= ST_OK;
			end else begin
				hash_q      <= hash_d;
				body_cnt_q  <= body_cnt_d;
				phase_q     <= phase_d;
				shift_q     <= shift_d;
				fidx_q      <= fidx_d;
				inc_left_q  <= inc_left_d;
				name_left_q <= name_left_d;
				key_q       <= key_d;
				count_q     <= count_d;
				size_q      <= size_d;
				code_seen_q <= code_seen_d;
				err_q       <= err_d;
			end
		end
	end

	// snapshot the finished record
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			hash_s2      <= hash_d;
			stored_s2    <= head.stored;
			body_cnt_s2  <= body_cnt_d;
			fill_s2      <= head.tail_fill;
			in_code_s2   <= (phase_d == PH_CODE);
			code_seen_s2 <= code_seen_d;
			key_s2       <= key_d;
			count_s2     <= count_d;
			size_s2      <= size_d;
			err_s2       <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (pop && head.last) begin
			vld_s2 <= 1'b1;
		end else if (adv_s2) begin
			vld_s2 <= 1'b0;
		end
	end

	assign total = (LENGTH_BITS+1)'(body_cnt_s2) + (LENGTH_BITS+1)'(fill_s2);

	always_comb begin
		if (total < (LENGTH_BITS+1)'(MIN_TOTAL)) begin
			status_s2 = ST_SHORT;
		end else if (stored_s2 != hash_s2) begin
			status_s2 = ST_CHECKSUM;
		end else if (err_s2 != ST_OK) begin
			status_s2 = err_s2;
		end else if (!in_code_s2) begin
			status_s2 = ST_TRUNCATED;
		end else if (32'(code_seen_s2) != size_s2) begin
			status_s2 = ST_LEN_MISMATCH;
		end else begin
			status_s2 = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			out_status_q <= status_s2;
			out_key_q    <= key_s2;
			out_count_q  <= count_s2;
			out_size_q   <= size_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s2) begin
			out_vld_q <= 1'b1;
		end else if (verdict_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign verdict_out.valid          = out_vld_q;
	assign verdict_out.status         = out_status_q;
	assign verdict_out.record_key     = out_key_q;
	assign verdict_out.include_total  = out_count_q;
	assign verdict_out.bytecode_bytes = out_size_q;

endmodule

[hw/rtl/cache_record_validator_core.sv]
// Top level of the cache record validator: configuration registers, front end,
// queue and back end. Depends on crv_pkg, crv_ifs, crv_front, crv_queue, crv_back.
//
//   port         dir   handshake          payload
//   rec_in       in    valid/ready        data_byte, last_byte
//   verdict_out  out   valid/ready        status, record_key, include_total, bytecode_bytes
//   apb          in    psel/penable       paddr, pwdata, pwrite -> prdata
//
// One byte per cycle while the queue has room; the FNV shift-add and parser take one queue entry
// a cycle unless a finished record waits on a stalled verdict stage. A record's last byte is queued,
// then passes through the verdict stage and the output register to verdict_out.
// Reset is asynchronous and needs no clearing pass; state and configuration registers return to defaults.
// A stalled verdict_out holds the output register; the queue absorbs up to four entries,
// after which rec_in.ready drops.
`include "cache_record_validator_core_assert.svh"

module cache_record_validator_core import crv_pkg::*; #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	crv_in_if.sink      rec_in,
	crv_out_if.source   verdict_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	crv_cfg_t   cfg_q;
	crv_reg_t   reg_idx;
	logic       q_push;
	crv_entry_t q_push_data;
	logic       q_pop;
	crv_entry_t q_head;
	crv_qstat_t q_stat;
	logic       last_acc;

	assign pready   = 1'b1;
	assign reg_idx  = crv_reg_t'(paddr[3:2]);
	assign last_acc = rec_in.valid && rec_in.ready && rec_in.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic          <= '0;
			cfg_q.version        <= '0;
			cfg_q.include_limit  <= 16'd256;
			cfg_q.bytecode_limit <= 25'd1048576;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_MAGIC:     cfg_q.magic          <= pwdata;
				REG_VERSION:   cfg_q.version        <= pwdata;
				REG_INC_LIMIT: cfg_q.include_limit  <= pwdata[15:0];
				REG_BC_LIMIT:  cfg_q.bytecode_limit <= pwdata[24:0];
				default:       cfg_q                <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAGIC:     prdata = cfg_q.magic;
			REG_VERSION:   prdata = cfg_q.version;
			REG_INC_LIMIT: prdata = {16'd0, cfg_q.include_limit};
			REG_BC_LIMIT:  prdata = {7'd0, cfg_q.bytecode_limit};
			default:       prdata = '0;
		endcase
	end

	crv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_in    (rec_in),
		.qstat     (q_stat),
		.push      (q_push),
		.push_data (q_push_data)
	);

	crv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	crv_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (q_head),
		.qstat       (q_stat),
		.pop         (q_pop),
		.verdict_out (verdict_out)
	);

	`CRV_ASSERT_NOW(a_pop_not_empty, clk, arst_n, q_pop, !q_stat.empty)
	`CRV_ASSERT_NOW(a_push_has_room, clk, arst_n, q_push, !q_stat.full || q_pop)
	`CRV_ASSERT_NEXT(a_last_queued, clk, arst_n, last_acc, !q_stat.empty)
	`CRV_ASSERT_NOW(a_status_range, clk, arst_n, verdict_out.valid, verdict_out.status <= ST_LEN_MISMATCH)

endmodule

[bench/cache_record_validator_core_tb.sv]
`timescale 1ns / 1ps
// Testbench of cache_record_validator_core: streams byte records, predicts each verdict
// and checks it. Depends on crv_pkg, crv_ifs and the block's RTL.
module cache_record_validator_core_tb;
	import crv_pkg::*;

	localparam int              LEN_BITS         = 32;
	localparam longint unsigned LEN_MAX          = (64'd1 << LEN_BITS) - 1;
	localparam int              CYCLE_LIMIT      = 400000;
	localparam int              PHASE_BYTES      = 100;
	localparam int              PHASE_RECORDS    = 2;
	localparam int              PRESSURE_BYTES   = 300;
	localparam int              PRESSURE_RECORDS = 6;
	localparam int              HOLD_OFF_CYCLES  = 300;
	localparam int              DRAIN_CYCLES     = 8;
	localparam int              N_DIRECTED       = 15;

	typedef struct packed {
		status_t     status;
		logic [63:0] key;
		logic [15:0] inc_count;
		logic [31:0] bc_size;
	} verdict_t;

	typedef enum int {
		RK_GOOD,
		RK_SHORT,
		RK_CHECKSUM,
		RK_MAGIC,
		RK_VERSION,
		RK_INCLUDES,
		RK_HUGE_COUNT,
		RK_TRUNC,
		RK_BC_ZERO,
		RK_BC_ODD,
		RK_BC_BIG,
		RK_LEN_LONG,
		RK_LEN_SHORT,
		RK_NOISE
	} flavor_t;

	// Tracks register settings and record state; queues the verdict each record must give.
	class record_verdicts;
		logic [31:0]     magic_cfg;
		logic [31:0]     version_cfg;
		logic [15:0]     inc_limit;
		logic [24:0]     bc_limit;
		logic [63:0]     hash;
		logic [7:0]      tail[8];
		int unsigned     tail_fill;
		longint unsigned body_count;
		phase_t          phase;
		logic [63:0]     shift_reg;
		int unsigned     field_idx;
		logic [15:0]     includes_left;
		logic [15:0]     name_left;
		logic [63:0]     key_held;
		logic [15:0]     count_held;
		logic [31:0]     size_held;
		longint unsigned code_seen;
		status_t         first_err;
		verdict_t        due[$];
		int              errors;

		function new();
			errors = 0;
			magic_cfg = 0;
			version_cfg = 0;
			inc_limit = 16'd256;
			bc_limit = 25'd1048576;
			clear_record();
		endfunction

		static function logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] b);
			return (h ^ {56'd0, b}) * 64'h0000_0100_0000_01b3;
		endfunction

		function void clear_record();
			hash = FNV_BASIS;
			foreach (tail[i]) tail[i] = 8'd0;
			tail_fill = 0;
			body_count = 0;
			phase = PH_MAGIC;
			shift_reg = 0;
			field_idx = 0;
			includes_left = 0;
			name_left = 0;
			key_held = 0;
			count_held = 0;
			size_held = 0;
			code_seen = 0;
			first_err = ST_OK;
		endfunction

		function void set_reg(crv_reg_t idx, logic [31:0] v);
			case (idx)
				REG_MAGIC: magic_cfg = v;
				REG_VERSION: version_cfg = v;
				REG_INC_LIMIT: inc_limit = v[15:0];
				default: bc_limit = v[24:0];
			endcase
		endfunction

		function void note_error(status_t code);
			if (first_err == ST_OK) first_err = code;
		endfunction

		function void parse_byte(logic [7:0] b);
			logic [63:0] val;
			int unsigned flen;
			if (phase == PH_DONE) return;
			if (phase == PH_CODE) begin
				if (code_seen < LEN_MAX) code_seen++;
				return;
			end
			if (phase == PH_NAME) begin
				name_left--;
				if (name_left == 0) phase = PH_IHASH;
				return;
			end
			val = shift_reg | ({56'd0, b} << (field_idx * 8));
			flen = (phase == PH_KEY || phase == PH_IHASH) ? 8 : (phase == PH_NAMELEN) ? 2 : 4;
			if (field_idx + 1 < flen) begin
				shift_reg = val;
				field_idx++;
				return;
			end
			shift_reg = 0;
			field_idx = 0;
			case (phase)
				PH_MAGIC: begin
					if (val[31:0] != magic_cfg) note_error(ST_MAGIC);
					phase = PH_VERSION;
				end
				PH_VERSION: begin
					if (val[31:0] != version_cfg) note_error(ST_VERSION);
					phase = PH_KEY;
				end
				PH_KEY: begin
					key_held = val;
					phase = PH_COUNT;
				end
				PH_COUNT: begin
					count_held = (val > 64'hFFFF) ? 16'hFFFF : val[15:0];
					if (val > {48'd0, inc_limit}) note_error(ST_INCLUDES);
					if (first_err != ST_OK) phase = PH_DONE;
					else begin
						includes_left = val[15:0];
						phase = (includes_left == 0) ? PH_SIZE : PH_NAMELEN;
					end
				end
				PH_NAMELEN: begin
					name_left = val[15:0];
					phase = (name_left == 0) ? PH_IHASH : PH_NAME;
				end
				PH_IHASH: begin
					includes_left--;
					phase = (includes_left == 0) ? PH_SIZE : PH_NAMELEN;
				end
				default: begin
					size_held = val[31:0];
					if (size_held == 0 || size_held > {7'd0, bc_limit} || size_held[1:0] != 2'd0) begin
						note_error(ST_BC_SIZE);
						phase = PH_DONE;
					end else phase = PH_CODE;
				end
			endcase
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			logic [63:0] stored;
			verdict_t v;
			if (tail_fill >= CHECK_BYTES) begin
				// oldest held byte leaves the delay line into the body
				hash = fnv_mix(hash, tail[0]);
				if (body_count < LEN_MAX) body_count++;
				parse_byte(tail[0]);
				for (int i = 0; i < 7; i++) tail[i] = tail[i + 1];
				tail[7] = b;
			end else begin
				tail[tail_fill] = b;
				tail_fill++;
			end
			if (!last) return;
			for (int i = 0; i < 8; i++) stored[8 * i +: 8] = tail[i];
			if (body_count + tail_fill < MIN_TOTAL) v.status = ST_SHORT;
			else if (stored != hash) v.status = ST_CHECKSUM;
			else if (first_err != ST_OK) v.status = first_err;
			else if (phase != PH_CODE) v.status = ST_TRUNCATED;
			else if (code_seen != {32'd0, size_held}) v.status = ST_LEN_MISMATCH;
			else v.status = ST_OK;
			v.key = key_held;
			v.inc_count = count_held;
			v.bc_size = size_held;
			due = {due, v};
			clear_record();
		endfunction

		function void match_verdict(logic [3:0] status, logic [63:0] key, logic [15:0] inc_count,
			logic [31:0] bc_size);
			verdict_t v;
			if (due.size() == 0) begin
				$display("%0t: verdict with none due, status %0d key %h", $time, status, key);
				errors++;
				return;
			end
			v = due.pop_front();
			if (status != v.status) begin
				$display("%0t: status expected %0d actual %0d", $time, v.status, status);
				errors++;
			end
			if (key != v.key) begin
				$display("%0t: record_key expected %h actual %h", $time, v.key, key);
				errors++;
			end
			if (inc_count != v.inc_count) begin
				$display("%0t: include_total expected %0d actual %0d", $time, v.inc_count, inc_count);
				errors++;
			end
			if (bc_size != v.bc_size) begin
				$display("%0t: bytecode_bytes expected %0d actual %0d", $time, v.bc_size, bc_size);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	crv_in_if  rec_if ();
	crv_out_if verdict_if ();

	cache_record_validator_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_in      (rec_if),
		.verdict_out (verdict_if),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	record_verdicts book;
	logic [7:0]     rec_q[$];
	int             send_idle = 0;
	int             recv_idle = 0;
	bit             hold_go = 0;
	int             hold_left = 0;
	int             phase_bytes;
	int             phase_records;
	int             cycle_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// verdict side: random stalls, plus one long hold-off on request
	initial begin
		verdict_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				verdict_if.ready <= 1'b0;
			end else if (hold_go) begin
				hold_go = 0;
				hold_left = HOLD_OFF_CYCLES;
				verdict_if.ready <= 1'b0;
			end else verdict_if.ready <= ($urandom_range(99, 0) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && verdict_if.valid === 1'b1 && verdict_if.ready)
			book.match_verdict(verdict_if.status, verdict_if.record_key, verdict_if.include_total,
				verdict_if.bytecode_bytes);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	task automatic send_byte(logic [7:0] b, logic last);
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle) begin
			rec_if.valid <= 1'b0;
			@(negedge clk);
		end
		rec_if.valid <= 1'b1;
		rec_if.data_byte <= b;
		rec_if.last_byte <= last;
		do @(posedge clk); while (!rec_if.ready);
		book.take_byte(b, last);
		phase_bytes++;
	endtask

	task automatic rest_sender();
		@(negedge clk);
		rec_if.valid <= 1'b0;
	endtask

	// write a register, then read it back in a following transfer
	task automatic reg_write(crv_reg_t idx, logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		book.set_reg(idx, v);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== v) begin
			$display("%0t: register %0d expected %h actual %h", $time, idx, v, prdata);
			book.errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_regs(logic [31:0] m, logic [31:0] ver, logic [15:0] inc, logic [24:0] bc);
		reg_write(REG_MAGIC, m);
		reg_write(REG_VERSION, ver);
		reg_write(REG_INC_LIMIT, {16'd0, inc});
		reg_write(REG_BC_LIMIT, {7'd0, bc});
	endtask

	task automatic drain();
		while (book.due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void put_le(logic [63:0] v, int n);
		for (int i = 0; i < n; i++) rec_q = {rec_q, v[8 * i +: 8]};
	endfunction

	function automatic void put_random(int n);
		repeat (n) rec_q = {rec_q, 8'($urandom)};
	endfunction

	// assemble one record of the given flavor into rec_q, checksum appended unless short or noise
	function automatic void build_record(flavor_t kind, int len);
		logic [31:0] magic;
		logic [31:0] version;
		logic [31:0] inc_count;
		logic [31:0] bc_size;
		logic [63:0] hash;
		int          n;
		int          size_end;
		int          code_len;
		int          cut;
		rec_q.delete();
		if (kind == RK_SHORT || kind == RK_NOISE) begin
			if (len != 0) n = len;
			else if (kind == RK_SHORT) n = $urandom_range(31, 1);
			else n = $urandom_range(120, 1);
			put_random(n);
			return;
		end
		magic = book.magic_cfg;
		version = book.version_cfg;
		if (kind == RK_MAGIC) magic ^= 32'd1 << $urandom_range(31, 0);
		if (kind == RK_VERSION) version ^= 32'd1 << $urandom_range(31, 0);
		if (kind == RK_INCLUDES)
			inc_count = (book.inc_limit == 16'hFFFF) ? 32'h10000 :
				$urandom_range(65535, book.inc_limit + 1);
		else if (kind == RK_HUGE_COUNT) inc_count = $urandom_range(32'hFFFF_FFFF, 32'h1_0000);
		else inc_count = $urandom_range((book.inc_limit < 3) ? book.inc_limit : 3, 0);
		put_le(64'(magic), 4);
		put_le(64'(version), 4);
		put_le({$urandom, $urandom}, 8);
		put_le(64'(inc_count), 4);
		if (kind == RK_INCLUDES || kind == RK_HUGE_COUNT) put_random($urandom_range(8, 0));
		else begin
			for (int i = 0; i < inc_count; i++) begin
				n = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 5) : $urandom_range(4, 0);
				put_le(64'(n), 2);
				put_random(n);
				put_le({$urandom, $urandom}, 8);
			end
			bc_size = $urandom_range(((book.bc_limit < 16) ? book.bc_limit : 16) / 4, 1) * 4;
			case (kind)
				RK_BC_ZERO: bc_size = 0;
				RK_BC_ODD: bc_size += $urandom_range(3, 1);
				RK_BC_BIG: begin
					if ($urandom_range(3, 0) == 0) bc_size = 32'hFFFF_FFFC;
					else bc_size = ({7'd0, book.bc_limit} + 32'd4) & ~32'd3;
				end
				default: ;
			endcase
			put_le(64'(bc_size), 4);
			size_end = rec_q.size();
			case (kind)
				RK_LEN_LONG: code_len = bc_size + $urandom_range(3, 1);
				RK_LEN_SHORT: code_len = $urandom_range(bc_size - 1, 0);
				RK_BC_ZERO, RK_BC_ODD, RK_BC_BIG: code_len = $urandom_range(8, 0);
				default: code_len = bc_size;
			endcase
			put_random(code_len);
			// cut the body before the size field completes, or at its end for a record with no includes
			if (kind == RK_TRUNC) begin
				cut = $urandom_range(size_end - 1, 24);
				while (rec_q.size() > cut) void'(rec_q.pop_back());
			end
		end
		hash = FNV_BASIS;
		foreach (rec_q[i]) hash = record_verdicts::fnv_mix(hash, rec_q[i]);
		if (kind == RK_CHECKSUM) hash ^= 64'd1 << $urandom_range(63, 0);
		put_le(hash, 8);
	endfunction

	task automatic send_record(flavor_t kind, int len);
		build_record(kind, len);
		foreach (rec_q[i]) send_byte(rec_q[i], i == rec_q.size() - 1);
		phase_records++;
	endtask

	initial begin
		flavor_t directed_kind[N_DIRECTED];
		int      directed_len[N_DIRECTED];
		flavor_t kind;
		int      byte_goal;
		int      record_goal;
		book = new();
		rec_if.valid = 1'b0;
		rec_if.data_byte = 8'd0;
		rec_if.last_byte = 1'b0;
		directed_kind = '{RK_SHORT, RK_SHORT, RK_NOISE, RK_GOOD, RK_CHECKSUM, RK_MAGIC,
			RK_VERSION, RK_INCLUDES, RK_HUGE_COUNT, RK_TRUNC, RK_BC_ZERO, RK_BC_ODD, RK_BC_BIG,
			RK_LEN_LONG, RK_LEN_SHORT};
		directed_len = '{1, 31, 32, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					send_idle = 11;
					recv_idle = 59;
				end
				1: begin
					send_idle = 59;
					recv_idle = 11;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			case (ph)
				1: set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 25'd4);
				2: set_regs(32'd0, 32'd0, 16'hFFFF, 25'd16777216);
				3: set_regs($urandom, $urandom, 16'($urandom_range(8, 1)), 25'($urandom_range(64, 4)));
				4: set_regs($urandom, $urandom, 16'($urandom), 25'($urandom_range(16777216, 4)));
				5: set_regs($urandom, $urandom, 16'd3, 25'd1048576);
				default: ;
			endcase
			phase_bytes = 0;
			phase_records = 0;
			byte_goal = (ph == 4) ? PRESSURE_BYTES : PHASE_BYTES;
			record_goal = (ph == 4) ? PRESSURE_RECORDS : PHASE_RECORDS;
			if (ph == 0)
				for (int i = 0; i < N_DIRECTED; i++) send_record(directed_kind[i], directed_len[i]);
			// stall the verdict side while bytes keep coming
			if (ph == 4) hold_go = 1;
			while (phase_bytes < byte_goal || phase_records < record_goal) begin
				if ($urandom_range(99, 0) < 55) kind = RK_GOOD;
				else kind = flavor_t'($urandom_range(int'(RK_NOISE), int'(RK_SHORT)));
				send_record(kind, 0);
			end
			rest_sender();
			drain();
		end

		if (book.errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
